@@ src/ale_pkg.sv @@
package ale_pkg;

   localparam int CMD_W   = 3;
   localparam int POS_W   = 9;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int FOUND_W = 8;
   localparam int COUNT_W = 9;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USED_W = STAT_W + FOUND_W + COUNT_W;

   localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PREPEND    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd5;
   localparam logic [CMD_W-1:0] CMD_FIND       = 3'd6;

   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL       = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD        = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 2'd3;

endpackage

@@ src/ale_ram.sv @@
module ale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/array_list_engine.sv @@
// Command flow: remove last and refused commands go straight to the result; append,
// prepend and insert write the new word (after shifting the words at p..count-1 up,
// from the end down, when p<count); remove first and erase shift the words after p
// down; find reads the list from index 0 and stops at the first hit or the end.
// Commands are taken one at a time, so a shift or search over a full list holds the
// block until it has walked the list. Reset: synchronous; clears the element count and
// the handshake state. The element store is not cleared.
module array_list_engine
   import ale_pkg::*;
#(
   parameter int CAPACITY   = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // position[8:0], value[40:9]
   input  logic [CMD_W-1:0]      req_tuser,  // command[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status[1:0], found_index[9:2], count[18:10]
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP,
      S_DOWN,
      S_FIND,
      S_FIN
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      rd_ff, rd_in;
   logic                  rd_act_ff, rd_act_in;
   logic                  pend_ff, pend_in;
   logic [CNT_W-1:0]      dst_ff, dst_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic [ADDR_W-1:0]     found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [DATA_WIDTH-1:0] ram_wr_data;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [DATA_WIDTH-1:0] ram_rd_data;

   logic [CMD_W-1:0]      cmd;
   logic [CMP_W-1:0]      pos_ext, cnt_ext, ins_ext, del_ext;
   logic [DATA_WIDTH-1:0] value_word;
   logic                  full;
   logic [CNT_W-1:0]      rd_dec, rd_inc;

   ale_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign cmd        = req_tuser;
   assign pos_ext    = CMP_W'(req_tdata[POS_W-1:0]);
   assign cnt_ext    = CMP_W'(count_ff);
   assign value_word = DATA_WIDTH'($signed(req_tdata[POS_W+VALUE_W-1:POS_W]));
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign rd_dec     = rd_ff - CNT_W'(1);
   assign rd_inc     = rd_ff + CNT_W'(1);

   always_comb begin
      case (cmd)
         CMD_APPEND:  ins_ext = cnt_ext;
         CMD_PREPEND: ins_ext = '0;
         default:     ins_ext = pos_ext;
      endcase
      del_ext = (cmd == CMD_ERASE) ? pos_ext : '0;
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      word_in      = word_ff;
      pos_in       = pos_ff;
      rd_in        = rd_ff;
      rd_act_in    = rd_act_ff;
      pend_in      = pend_ff;
      dst_in       = dst_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ADDR_W'(dst_ff);
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = ADDR_W'(rd_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               word_in   = value_word;
               status_in = ST_OK;
               found_in  = '0;
               pend_in   = 1'b0;
               state_in  = S_FIN;
               case (cmd)
                  CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
                     if (ins_ext > cnt_ext) begin
                        status_in = ST_BAD;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in    = CNT_W'(ins_ext);
                        rd_in     = count_ff;
                        rd_act_in = (ins_ext != cnt_ext);
                        state_in  = S_UP;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (count_ff == '0) begin
                        status_in = ST_BAD;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_POP_FRONT, CMD_ERASE: begin
                     if (del_ext >= cnt_ext) begin
                        status_in = ST_BAD;
                     end else begin
                        pos_in    = CNT_W'(del_ext);
                        rd_in     = CNT_W'(del_ext) + CNT_W'(1);
                        rd_act_in = (CNT_W'(del_ext) + CNT_W'(1)) < count_ff;
                        state_in  = S_DOWN;
                     end
                  end
                  CMD_FIND: begin
                     status_in = ST_NOT_FOUND;
                     rd_in     = '0;
                     rd_act_in = (count_ff != '0);
                     state_in  = S_FIND;
                  end
                  default: begin
                     status_in = ST_BAD;
                  end
               endcase
            end
         end

         S_UP: begin
            ram_rd_addr = ADDR_W'(rd_dec);
            pend_in     = rd_act_ff;
            if (rd_act_ff) begin
               dst_in    = rd_ff;
               rd_in     = rd_dec;
               rd_act_in = (rd_dec > pos_ff);
            end
            if (pend_ff) begin
               ram_wr_en = 1'b1;
            end else if (!rd_act_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = ADDR_W'(pos_ff);
               ram_wr_data = word_ff;
               count_in    = count_ff + CNT_W'(1);
               state_in    = S_FIN;
            end
         end

         S_DOWN: begin
            pend_in = rd_act_ff;
            if (rd_act_ff) begin
               dst_in    = rd_dec;
               rd_in     = rd_inc;
               rd_act_in = (rd_inc < count_ff);
            end
            if (pend_ff) begin
               ram_wr_en = 1'b1;
            end else if (!rd_act_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FIN;
            end
         end

         S_FIND: begin
            pend_in = rd_act_ff;
            if (rd_act_ff) begin
               dst_in    = rd_ff;
               rd_in     = rd_inc;
               rd_act_in = (rd_inc < count_ff);
            end
            if (pend_ff && (ram_rd_data == word_ff)) begin
               status_in = ST_OK;
               found_in  = ADDR_W'(dst_ff);
               rd_act_in = 1'b0;
               pend_in   = 1'b0;
               state_in  = S_FIN;
            end else if (!pend_ff && !rd_act_ff) begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({COUNT_W'(count_ff), FOUND_W'(found_ff), status_ff});
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_act_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_act_ff    <= rd_act_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      pos_ff      <= pos_in;
      rd_ff       <= rd_in;
      dst_ff      <= dst_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ src/ale_checker.sv @@
module ale_checker
   import ale_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [STAT_W-1:0]  rsp_status;
   logic [FOUND_W-1:0] rsp_found;
   logic [COUNT_W-1:0] rsp_count;

   assign rsp_status = rsp_tdata[STAT_W-1:0];
   assign rsp_found  = rsp_tdata[STAT_W+FOUND_W-1:STAT_W];
   assign rsp_count  = rsp_tdata[RSP_USED_W-1:STAT_W+FOUND_W];

   // one command in flight: busy right after an accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after an accepted beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != ST_OK) |-> (rsp_found == '0))
      else $error("found_index nonzero on a failed command");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == ST_FULL) |-> (rsp_count == COUNT_W'(CAPACITY)))
      else $error("full status with count below capacity");

endmodule

bind array_list_engine ale_checker #(.CAPACITY(CAPACITY)) u_ale_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

@@ verif/tb_array_list_engine.sv @@
`timescale 1ns / 100ps

module tb_array_list_engine;
   import ale_pkg::*;

   localparam int                 LIST_DEPTH   = 256;
   localparam int                 LIST_WIDTH   = 32;
   localparam int                 RANDOM_ITEMS = 950;
   localparam int                 DRAIN_CYCLES = 2 * LIST_DEPTH + 64;
   localparam int                 CYCLE_LIMIT  = 1_200_000;
   localparam logic [CMD_W-1:0]   CMD_UNUSED   = 3'd7;
   localparam logic [POS_W-1:0]   POS_MAX      = '1;

   typedef struct {
      logic [STAT_W-1:0]  status;
      logic [FOUND_W-1:0] found_index;
      logic [COUNT_W-1:0] count;
   } reply_type;

   class list_scoreboard;
      logic [LIST_WIDTH-1:0] shadow_words [LIST_DEPTH];
      int unsigned           shadow_count;
      reply_type             expected_replies [$];
      int                    errors;
      int                    replies_checked;
      int                    full_hits;
      int                    bad_hits;
      int                    miss_hits;
      int                    peak_count;

      function new();
         shadow_count    = 0;
         errors          = 0;
         replies_checked = 0;
         full_hits       = 0;
         bad_hits        = 0;
         miss_hits       = 0;
         peak_count      = 0;
      endfunction

      function void open_gap(int unsigned at, logic [LIST_WIDTH-1:0] word);
         for (int unsigned i = shadow_count; i > at; i--)
            shadow_words[i] = shadow_words[i-1];
         shadow_words[at] = word;
         shadow_count++;
      endfunction

      function void close_gap(int unsigned at);
         for (int unsigned i = at; i + 1 < shadow_count; i++)
            shadow_words[i] = shadow_words[i+1];
         shadow_count--;
      endfunction

      function void accept_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [VALUE_W-1:0] value);
         reply_type r;
         bit        full;
         full          = (shadow_count >= LIST_DEPTH);
         r.status      = ST_OK;
         r.found_index = '0;
         case (cmd)
            CMD_APPEND: begin
               if (full) r.status = ST_FULL;
               else open_gap(shadow_count, value);
            end
            CMD_POP_BACK: begin
               if (shadow_count == 0) r.status = ST_BAD;
               else shadow_count--;
            end
            CMD_PREPEND: begin
               if (full) r.status = ST_FULL;
               else open_gap(0, value);
            end
            CMD_POP_FRONT: begin
               if (shadow_count == 0) r.status = ST_BAD;
               else close_gap(0);
            end
            CMD_INSERT: begin
               if (pos > shadow_count) r.status = ST_BAD;
               else if (full) r.status = ST_FULL;
               else open_gap(pos, value);
            end
            CMD_ERASE: begin
               if (pos >= shadow_count) r.status = ST_BAD;
               else close_gap(pos);
            end
            CMD_FIND: begin
               r.status = ST_NOT_FOUND;
               for (int unsigned i = 0; i < shadow_count; i++) begin
                  if (shadow_words[i] == value) begin
                     r.status      = ST_OK;
                     r.found_index = i[FOUND_W-1:0];
                     break;
                  end
               end
            end
            default: r.status = ST_BAD;
         endcase
         r.count = shadow_count[COUNT_W-1:0];
         if (r.status == ST_FULL) full_hits++;
         if (r.status == ST_BAD) bad_hits++;
         if (r.status == ST_NOT_FOUND) miss_hits++;
         if (shadow_count > peak_count) peak_count = shadow_count;
         expected_replies.push_back(r);
      endfunction

      function void check_reply(logic [RSP_DATA_W-1:0] data);
         reply_type want;
         if (expected_replies.size() == 0) begin
            $error("unexpected reply beat: tdata=%h", data);
            errors++;
            return;
         end
         want = expected_replies.pop_front();
         replies_checked++;
         if (data[1:0] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, data[1:0]);
            errors++;
         end
         if (data[9:2] !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index, data[9:2]);
            errors++;
         end
         if (data[18:10] !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, data[18:10]);
            errors++;
         end
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   list_scoreboard sb;
   int             burst_left  = 0;
   int             items_sent  = 0;
   int             cycles      = 0;
   int             stall_hold  = 0;
   int             stall_mode  = 0;
   int             mode_cycles = 0;

   always #4 clock = ~clock;

   array_list_engine #(
      .CAPACITY   (LIST_DEPTH),
      .DATA_WIDTH (LIST_WIDTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] value);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, value, pos};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.accept_command(cmd, pos, value);
      items_sent++;
      burst_left--;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         3, 4:    return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // receiver stall pattern
   always @(negedge clock) begin
      logic rdy;
      rdy = rsp_tready;
      mode_cycles++;
      if (mode_cycles >= 300) begin
         mode_cycles = 0;
         stall_mode  = $urandom_range(0, 2);
      end
      if (stall_hold > 0) begin
         stall_hold--;
      end else begin
         case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(0, 3) != 0);
            default: begin
               rdy        = ~rdy;
               stall_hold = $urandom_range(0, 15);
            end
         endcase
      end
      rsp_tready <= rdy;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_reply(rsp_tdata);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_array_list_engine: FAIL");
         $finish;
      end
   end

   initial begin
      int                 done;
      int                 seg;
      int                 seg_len;
      int                 target;
      int                 r;
      int                 n;
      bit                 grow;
      logic [CMD_W-1:0]   cmd;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] value;

      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list, bad positions and an unused command
      send_item(CMD_FIND, 9'd0, 32'h0);
      send_item(CMD_POP_BACK, 9'd0, 32'h0);
      send_item(CMD_POP_FRONT, 9'd0, 32'h0);
      send_item(CMD_ERASE, 9'd0, 32'h0);
      send_item(CMD_INSERT, 9'd1, 32'h1);
      send_item(CMD_UNUSED, 9'd0, 32'h0);
      // extremes, every add path
      send_item(CMD_APPEND, 9'd0, 32'h7FFF_FFFF);
      send_item(CMD_APPEND, POS_MAX, 32'h8000_0000);
      send_item(CMD_PREPEND, 9'd0, 32'h0);
      send_item(CMD_PREPEND, 9'd0, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, sb.shadow_count[POS_W-1:0], 32'h5);
      send_item(CMD_INSERT, 9'd0, 32'h1);
      send_item(CMD_INSERT, 9'd2, 32'h1234_5678);
      send_item(CMD_INSERT, POS_MAX, 32'hDEAD_BEEF);
      // find hit and miss
      send_item(CMD_FIND, 9'd0, 32'h8000_0000);
      send_item(CMD_FIND, POS_MAX, 32'hFFFF_FFFF);
      send_item(CMD_FIND, 9'd0, 32'd42);
      // erase edges
      send_item(CMD_ERASE, sb.shadow_count[POS_W-1:0], 32'h0);
      send_item(CMD_ERASE, 9'd0, 32'h0);
      send_item(CMD_ERASE, sb.shadow_count[POS_W-1:0] - 9'd1, 32'h0);
      send_item(CMD_ERASE, POS_MAX, 32'h0);
      send_item(CMD_POP_BACK, 9'd0, 32'h0);
      send_item(CMD_POP_FRONT, 9'd0, 32'h0);
      // duplicate key returns the first index
      send_item(CMD_APPEND, 9'd0, 32'h0);
      send_item(CMD_FIND, 9'd0, 32'h0);
      send_item(CMD_UNUSED, POS_MAX, 32'hFFFF_FFFF);

      done = 0;
      seg  = 0;
      while (done < RANDOM_ITEMS) begin
         if (seg == 1) begin
            target  = LIST_DEPTH;
            seg_len = 450;
         end else begin
            target  = (seg == 2 || $urandom_range(0, 3) == 0) ? 0
                                                             : $urandom_range(0, LIST_DEPTH);
            seg_len = $urandom_range(40, 100);
         end
         for (int k = 0; k < seg_len && done < RANDOM_ITEMS; k++) begin
            n     = sb.shadow_count;
            r     = $urandom_range(0, 99);
            pos   = POS_W'($urandom_range(0, 511));
            value = pick_value();
            if (r < 10) begin
               cmd = CMD_FIND;
               if (n > 0 && $urandom_range(0, 9) < 6) value = sb.shadow_words[$urandom_range(0, n-1)];
            end else if (r < 11) begin
               cmd   = CMD_UNUSED;
               value = $urandom;
            end else if (r < 13) begin
               cmd   = CMD_W'($urandom_range(0, 7));
               value = $urandom;
            end else begin
               grow = (n < target) ? ($urandom_range(0, 99) < 88) : ($urandom_range(0, 99) < 12);
               if (grow) cmd = ($urandom_range(0, 2) == 0) ? CMD_APPEND
                                : ($urandom_range(0, 1) == 0) ? CMD_PREPEND : CMD_INSERT;
               else      cmd = ($urandom_range(0, 2) == 0) ? CMD_POP_BACK
                                : ($urandom_range(0, 1) == 0) ? CMD_POP_FRONT : CMD_ERASE;
               r = $urandom_range(0, 9);
               if (cmd == CMD_INSERT && r < 8) pos = POS_W'($urandom_range(0, n));
               else if (cmd == CMD_INSERT && r == 8) pos = POS_W'(n);
               else if (cmd == CMD_ERASE && n > 0 && r < 9) pos = POS_W'($urandom_range(0, n-1));
            end
            send_item(cmd, pos, value);
            done++;
         end
         seg++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d commands sent, %0d replies checked, peak length %0d", items_sent,
               sb.replies_checked, sb.peak_count);
      $display("full refusals %0d, bad position or empty %0d, find misses %0d",
               sb.full_hits, sb.bad_hits, sb.miss_hits);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_array_list_engine: PASS");
      end else begin
         $display("tb_array_list_engine: FAIL");
      end
      $finish;
   end

endmodule
